@@ hw/rtl/acsfc_pkg.sv @@
// Shared types, codes and constants of the air-conditioner status frame codec.
// Used by the controller, the datapath and the top level; depends on nothing.

package acsfc_pkg;

   typedef enum logic [1:0] {
      CMD_RX_BYTE  = 2'd0,
      CMD_GAP      = 2'd1,
      CMD_SETTINGS = 2'd2,
      CMD_PROBE    = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      EV_STATUS    = 2'd0,
      EV_OTHER     = 2'd1,
      EV_CHECK_ERR = 2'd2,
      EV_TX_BYTE   = 2'd3
   } event_type;

   localparam int unsigned DATA_BYTES = 12;
   localparam logic [3:0] LAST_INDEX   = 4'd12;
   localparam logic [7:0] CHECK_XOR    = 8'h55;
   localparam logic [7:0] TYPE_MASTER  = 8'hA8;
   localparam logic [7:0] TYPE_UNIT    = 8'hC8;
   localparam logic [7:0] PROBE_BYTE8  = 8'h40;
   localparam logic [7:0] PROBE_BYTE10 = 8'h80;
   localparam logic [3:0] TARGET_FLAG  = 4'h1;
   localparam logic [6:0] ROOM_OFFSET  = 7'd20;
   localparam logic [6:0] ROOM_RESET   = 7'd40;
   localparam logic [4:0] TARGET_BASE  = 5'd15;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic rx_take;
      logic gap;
      logic tx_start;
      logic tx_load;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic frame_full;
      logic tx_final;
   } dp_status_type;

   function automatic logic [2:0] mode_code(input logic [2:0] req);
      logic [2:0] code;
      case (req)
         3'd1:    code = 3'd0;
         3'd2:    code = 3'd1;
         3'd3:    code = 3'd2;
         3'd4:    code = 3'd3;
         3'd5:    code = 3'd4;
         default: code = 3'd7;
      endcase
      return code;
   endfunction

   function automatic logic [2:0] fan_code(input logic [2:0] req);
      logic [2:0] code;
      case (req)
         3'd1:    code = 3'd3;
         3'd2:    code = 3'd2;
         3'd3:    code = 3'd1;
         3'd4:    code = 3'd0;
         default: code = 3'd7;
      endcase
      return code;
   endfunction

endpackage

@@ hw/rtl/aircon_status_frame_codec_unit.sv @@
// Top level of the air-conditioner status frame codec.
// Instantiates acsfc_ctrl and acsfc_datapath; uses acsfc_pkg types.
//
//   channel   direction   handshake               payload
//   req_      in          req_valid / req_ready   command, rx byte, settings request
//   rsp_      out         rsp_valid / rsp_ready   event, tx byte, last mark, decoded status
//
// A received byte or a gap timeout is accepted as one transaction; the thirteenth byte of a
// frame loads one result into the output register when it is accepted.
// A settings or probe request is accepted and then sends thirteen bytes, one byte
// per cycle while the result register is free, from the transmit index counter.
// Reset is synchronous and active high; it clears framing and the status store.
// A stalled result holds the frame builder and blocks new transactions.

module aircon_status_frame_codec_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_command,
   input  logic [7:0] req_rx_byte,
   input  logic       req_power_on,
   input  logic [2:0] req_mode_request,
   input  logic [2:0] req_fan_request,
   input  logic       req_swing_request,
   input  logic [4:0] req_target_temp,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_event_res,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_last_byte,
   output logic       rsp_power_state,
   output logic [2:0] rsp_mode_state,
   output logic [2:0] rsp_fan_state,
   output logic [4:0] rsp_target_state,
   output logic       rsp_swing_state,
   output logic [6:0] rsp_room_temp_half
);

   acsfc_pkg::dp_cmd_type    dp_cmd;
   acsfc_pkg::dp_status_type dp_status;

   acsfc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status)
   );

   acsfc_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .dp_cmd             (dp_cmd),
      .dp_status          (dp_status),
      .req_rx_byte        (req_rx_byte),
      .req_power_on       (req_power_on),
      .req_mode_request   (req_mode_request),
      .req_fan_request    (req_fan_request),
      .req_swing_request  (req_swing_request),
      .req_target_temp    (req_target_temp),
      .req_command        (req_command),
      .rsp_event_res      (rsp_event_res),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_last_byte      (rsp_last_byte),
      .rsp_power_state    (rsp_power_state),
      .rsp_mode_state     (rsp_mode_state),
      .rsp_fan_state      (rsp_fan_state),
      .rsp_target_state   (rsp_target_state),
      .rsp_swing_state    (rsp_swing_state),
      .rsp_room_temp_half (rsp_room_temp_half)
   );

endmodule

@@ hw/rtl/acsfc_ctrl.sv @@
// Controller of the status frame codec: handshakes and transmit sequencing.
// Depends on acsfc_pkg for commands and the datapath command and status structs.

module acsfc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_command,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output acsfc_pkg::dp_cmd_type  dp_cmd,
   input  acsfc_pkg::dp_status_type dp_status
);

   typedef enum logic {
      S_IDLE,
      S_TX
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;
   logic      accept;
   logic      rx_result;
   acsfc_pkg::command_type cmd;

   assign cmd       = acsfc_pkg::command_type'(req_command);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      dp_cmd    = '0;
      state_in  = state_ff;
      rx_result = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (cmd)
                  acsfc_pkg::CMD_RX_BYTE: begin
                     dp_cmd.rx_take = 1'b1;
                     rx_result      = dp_status.frame_full;
                  end
                  acsfc_pkg::CMD_GAP: begin
                     dp_cmd.gap = 1'b1;
                  end
                  default: begin
                     dp_cmd.tx_start = 1'b1;
                     state_in        = S_TX;
                  end
               endcase
            end
         end
         S_TX: begin
            dp_cmd.tx_load = slot_free;
            if (slot_free && dp_status.tx_final) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (rx_result || dp_cmd.tx_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hw/rtl/acsfc_datapath.sv @@
// Datapath of the status frame codec: framing, check byte, status store,
// transmit frame builder and result register. Depends on acsfc_pkg.

module acsfc_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  acsfc_pkg::dp_cmd_type    dp_cmd,
   output acsfc_pkg::dp_status_type dp_status,
   input  logic [7:0]               req_rx_byte,
   input  logic                     req_power_on,
   input  logic [2:0]               req_mode_request,
   input  logic [2:0]               req_fan_request,
   input  logic                     req_swing_request,
   input  logic [4:0]               req_target_temp,
   input  logic [1:0]               req_command,
   output logic [1:0]               rsp_event_res,
   output logic [7:0]               rsp_tx_byte,
   output logic                     rsp_last_byte,
   output logic                     rsp_power_state,
   output logic [2:0]               rsp_mode_state,
   output logic [2:0]               rsp_fan_state,
   output logic [4:0]               rsp_target_state,
   output logic                     rsp_swing_state,
   output logic [6:0]               rsp_room_temp_half
);

   logic [3:0] byte_count_ff, byte_count_in;
   logic [7:0] run_sum_ff, run_sum_in;
   logic [7:0] frame_ff [acsfc_pkg::DATA_BYTES];
   logic [7:0] store_ff [acsfc_pkg::DATA_BYTES];
   logic [6:0] room_ff, room_in;
   logic       frame_we, store_we;

   logic [3:0] tx_idx_ff, tx_idx_in;
   logic [7:0] tx_sum_ff, tx_sum_in;
   logic       tx_probe_ff;
   logic       tx_power_ff;
   logic [2:0] tx_mode_ff;
   logic [2:0] tx_fan_ff;
   logic       tx_swing_ff;
   logic [3:0] tx_target_ff;
   logic [7:0] tx_byte;

   logic [1:0] out_event_ff, out_event_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;

   logic [2:0] mode_field;
   logic [2:0] fan_field;

   assign dp_status.frame_full = (byte_count_ff == acsfc_pkg::LAST_INDEX);
   assign dp_status.tx_final   = (tx_idx_ff == acsfc_pkg::LAST_INDEX);

   // Byte of the outgoing frame at the current transmit index.
   always_comb begin
      tx_byte = 8'h00;
      if (tx_idx_ff == acsfc_pkg::LAST_INDEX) begin
         tx_byte = tx_sum_ff ^ acsfc_pkg::CHECK_XOR;
      end else if (tx_idx_ff == 4'd0) begin
         tx_byte = acsfc_pkg::TYPE_MASTER;
      end else if (tx_probe_ff) begin
         case (tx_idx_ff)
            4'd8:    tx_byte = acsfc_pkg::PROBE_BYTE8;
            4'd10:   tx_byte = acsfc_pkg::PROBE_BYTE10;
            default: tx_byte = 8'h00;
         endcase
      end else begin
         case (tx_idx_ff)
            4'd1:    tx_byte = {tx_fan_ff, tx_mode_ff, tx_power_ff, 1'b1};
            4'd2:    tx_byte = {tx_swing_ff, 1'b0, store_ff[2][5:0]};
            4'd5:    tx_byte = {store_ff[5][7:1], 1'b0};
            4'd6:    tx_byte = {acsfc_pkg::TARGET_FLAG, tx_target_ff};
            4'd3, 4'd4, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11:
               tx_byte = store_ff[tx_idx_ff];
            default: tx_byte = 8'h00;
         endcase
      end
   end

   always_comb begin
      byte_count_in = byte_count_ff;
      run_sum_in    = run_sum_ff;
      room_in       = room_ff;
      frame_we      = 1'b0;
      store_we      = 1'b0;
      tx_idx_in     = tx_idx_ff;
      tx_sum_in     = tx_sum_ff;
      out_event_in  = out_event_ff;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      if (dp_cmd.gap) begin
         byte_count_in = 4'd0;
         run_sum_in    = 8'h00;
      end else if (dp_cmd.rx_take) begin
         if (!dp_status.frame_full) begin
            frame_we      = 1'b1;
            byte_count_in = byte_count_ff + 4'd1;
            run_sum_in    = run_sum_ff + req_rx_byte;
         end else begin
            byte_count_in = 4'd0;
            run_sum_in    = 8'h00;
            out_byte_in   = 8'h00;
            out_last_in   = 1'b0;
            if (req_rx_byte != (run_sum_ff ^ acsfc_pkg::CHECK_XOR)) begin
               out_event_in = acsfc_pkg::EV_CHECK_ERR;
            end else if (frame_ff[0] == acsfc_pkg::TYPE_UNIT) begin
               out_event_in = acsfc_pkg::EV_STATUS;
               store_we     = 1'b1;
               room_in      = {1'b0, frame_ff[7][5:0]} + acsfc_pkg::ROOM_OFFSET;
            end else begin
               out_event_in = acsfc_pkg::EV_OTHER;
            end
         end
      end
      if (dp_cmd.tx_start) begin
         tx_idx_in = 4'd0;
         tx_sum_in = 8'h00;
      end else if (dp_cmd.tx_load) begin
         tx_idx_in    = tx_idx_ff + 4'd1;
         tx_sum_in    = tx_sum_ff + tx_byte;
         out_event_in = acsfc_pkg::EV_TX_BYTE;
         out_byte_in  = tx_byte;
         out_last_in  = dp_status.tx_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= 4'd0;
         run_sum_ff    <= 8'h00;
         room_ff       <= acsfc_pkg::ROOM_RESET;
         tx_idx_ff     <= 4'd0;
         tx_sum_ff     <= 8'h00;
         for (int i = 0; i < acsfc_pkg::DATA_BYTES; i++) begin
            store_ff[i] <= 8'h00;
         end
      end else begin
         byte_count_ff <= byte_count_in;
         run_sum_ff    <= run_sum_in;
         room_ff       <= room_in;
         tx_idx_ff     <= tx_idx_in;
         tx_sum_ff     <= tx_sum_in;
         if (store_we) begin
            for (int i = 0; i < acsfc_pkg::DATA_BYTES; i++) begin
               store_ff[i] <= frame_ff[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_ff[byte_count_ff] <= req_rx_byte;
      end
      if (dp_cmd.tx_start) begin
         tx_probe_ff  <= (acsfc_pkg::command_type'(req_command) == acsfc_pkg::CMD_PROBE);
         tx_power_ff  <= req_power_on;
         tx_mode_ff   <= acsfc_pkg::mode_code(req_mode_request);
         tx_fan_ff    <= acsfc_pkg::fan_code(req_fan_request);
         tx_swing_ff  <= req_swing_request;
         tx_target_ff <= req_target_temp[3:0] + 4'd1;
      end
      out_event_ff <= out_event_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
   end

   // Decoded status follows the store, which only changes when the result
   // register is free or being emptied.
   assign mode_field = store_ff[1][4:2];
   assign fan_field  = store_ff[1][7:5];

   always_comb begin
      if (mode_field <= 3'd4) begin
         rsp_mode_state = mode_field + 3'd1;
      end else begin
         rsp_mode_state = 3'd4;
      end
      case (fan_field)
         3'd0:    rsp_fan_state = 3'd4;
         3'd1:    rsp_fan_state = 3'd3;
         3'd2:    rsp_fan_state = 3'd2;
         default: rsp_fan_state = 3'd1;
      endcase
   end

   assign rsp_power_state    = store_ff[1][1];
   assign rsp_swing_state    = store_ff[2][7];
   assign rsp_target_state   = {1'b0, store_ff[6][3:0]} + acsfc_pkg::TARGET_BASE
                               + {4'd0, store_ff[5][0]};
   assign rsp_room_temp_half = room_ff;
   assign rsp_event_res      = out_event_ff;
   assign rsp_tx_byte        = out_byte_ff;
   assign rsp_last_byte      = out_last_ff;

endmodule

@@ sim/acsfc_tb_pkg.sv @@
// Scoreboard for the air-conditioner status frame codec testbench: result record,
// frame constants and a class that predicts and checks every result transaction.
// Depends on acsfc_pkg for the command and event codes.

package acsfc_tb_pkg;

   import acsfc_pkg::*;

   localparam bit [7:0] FRAME_CHECK_MASK = 8'h55;
   localparam bit [7:0] HOST_FRAME_TYPE  = 8'hA8;
   localparam bit [7:0] UNIT_FRAME_TYPE  = 8'hC8;
   localparam bit [7:0] UNIT_TYPE_MASK   = 8'hF8;
   localparam bit [7:0] ROOM_TEMP_MASK   = 8'h3F;
   localparam bit [7:0] TARGET_MARK      = 8'h10;
   localparam bit [7:0] PROBE_BYTE_8     = 8'h40;
   localparam bit [7:0] PROBE_BYTE_10    = 8'h80;
   localparam bit [6:0] ROOM_BASE_HALF   = 7'd20;
   localparam bit [6:0] ROOM_AFTER_RESET = 7'd40;
   localparam int unsigned PAYLOAD_LEN   = 12;
   localparam int unsigned FRAME_LEN     = 13;
   localparam int unsigned REPORT_LIMIT  = 10;

   typedef enum int {
      FRAME_STATUS,
      FRAME_OTHER,
      FRAME_BAD_CHECK,
      FRAME_CUT
   } frame_kind_type;

   typedef struct packed {
      event_type  ev;
      logic [7:0] tx_byte;
      logic       last_byte;
      logic       power;
      logic [2:0] mode;
      logic [2:0] fan;
      logic [4:0] target;
      logic       swing;
      logic [6:0] room_half;
   } codec_result_type;

   class status_codec_scoreboard;
      int unsigned      rx_count;
      bit [7:0]         rx_sum;
      bit [7:0]         rx_frame [PAYLOAD_LEN];
      bit [7:0]         status_store [FRAME_LEN];
      bit [6:0]         room_half;
      codec_result_type pending_results [$];
      int unsigned      compared;
      int unsigned      failures;
      int unsigned      status_frames;
      int unsigned      other_frames;
      int unsigned      check_errors;
      int unsigned      frames_sent;

      function new();
         rx_count = 0;
         rx_sum = 8'h00;
         foreach (rx_frame[i]) rx_frame[i] = 8'h00;
         foreach (status_store[i]) status_store[i] = 8'h00;
         room_half = ROOM_AFTER_RESET;
         compared = 0;
         failures = 0;
         status_frames = 0;
         other_frames = 0;
         check_errors = 0;
         frames_sent = 0;
      endfunction

      function int unsigned results_outstanding();
         return pending_results.size();
      endfunction

      function bit [2:0] encode_mode(bit [2:0] req);
         case (req)
            3'd1:    return 3'd0;
            3'd2:    return 3'd1;
            3'd3:    return 3'd2;
            3'd4:    return 3'd3;
            3'd5:    return 3'd4;
            default: return 3'd7;
         endcase
      endfunction

      function bit [2:0] encode_fan(bit [2:0] req);
         case (req)
            3'd1:    return 3'd3;
            3'd2:    return 3'd2;
            3'd3:    return 3'd1;
            3'd4:    return 3'd0;
            default: return 3'd7;
         endcase
      endfunction

      function void queue_decoded_result(event_type ev, bit [7:0] tx, bit last);
         codec_result_type r;
         bit [2:0] mv;
         bit [2:0] fv;
         mv = status_store[1][4:2];
         fv = status_store[1][7:5];
         r.ev = ev;
         r.tx_byte = tx;
         r.last_byte = last;
         r.power = status_store[1][1];
         r.mode = (mv <= 3'd4) ? mv + 3'd1 : 3'd4;
         case (fv)
            3'd0:    r.fan = 3'd4;
            3'd1:    r.fan = 3'd3;
            3'd2:    r.fan = 3'd2;
            default: r.fan = 3'd1;
         endcase
         r.target = {1'b0, status_store[6][3:0]} + 5'd15 + {4'b0, status_store[5][0]};
         r.swing = status_store[2][7];
         r.room_half = room_half;
         pending_results.push_back(r);
      endfunction

      function void note_request(command_type cmd, bit [7:0] rx, bit pwr, bit [2:0] mode_req,
                                 bit [2:0] fan_req, bit swing_req, bit [4:0] target);
         bit [7:0] f [FRAME_LEN];
         bit [7:0] sum;
         bit [4:0] tcode;
         event_type ev;
         case (cmd)
            CMD_GAP: begin
               rx_count = 0;
               rx_sum = 8'h00;
            end
            CMD_RX_BYTE: begin
               if (rx_count < PAYLOAD_LEN) begin
                  rx_frame[rx_count] = rx;
                  rx_sum += rx;
                  rx_count++;
               end else begin
                  if (rx != (rx_sum ^ FRAME_CHECK_MASK)) begin
                     ev = EV_CHECK_ERR;
                     check_errors++;
                  end else if ((rx_frame[0] & UNIT_TYPE_MASK) == UNIT_FRAME_TYPE &&
                               rx_frame[0][2:0] == 3'd0) begin
                     for (int k = 0; k < PAYLOAD_LEN; k++) status_store[k] = rx_frame[k];
                     status_store[PAYLOAD_LEN] = rx;
                     room_half = 7'(rx_frame[7] & ROOM_TEMP_MASK) + ROOM_BASE_HALF;
                     ev = EV_STATUS;
                     status_frames++;
                  end else begin
                     ev = EV_OTHER;
                     other_frames++;
                  end
                  rx_count = 0;
                  rx_sum = 8'h00;
                  queue_decoded_result(ev, 8'h00, 1'b0);
               end
            end
            default: begin
               foreach (f[i]) f[i] = 8'h00;
               f[0] = HOST_FRAME_TYPE;
               if (cmd == CMD_SETTINGS) begin
                  tcode = target - 5'd15;
                  f[1] = {encode_fan(fan_req), encode_mode(mode_req), pwr, 1'b1};
                  f[2] = {swing_req, 1'b0, status_store[2][5:0]};
                  f[3] = status_store[3];
                  f[4] = status_store[4];
                  f[5] = {status_store[5][7:1], 1'b0};
                  f[6] = TARGET_MARK | {4'h0, tcode[3:0]};
                  for (int k = 7; k < PAYLOAD_LEN; k++) f[k] = status_store[k];
               end else begin
                  f[8] = PROBE_BYTE_8;
                  f[10] = PROBE_BYTE_10;
               end
               sum = 8'h00;
               for (int k = 0; k < PAYLOAD_LEN; k++) sum += f[k];
               f[PAYLOAD_LEN] = sum ^ FRAME_CHECK_MASK;
               for (int k = 0; k < FRAME_LEN; k++) begin
                  queue_decoded_result(EV_TX_BYTE, f[k], k == FRAME_LEN - 1);
               end
               frames_sent++;
            end
         endcase
      endfunction

      function string describe(codec_result_type r);
         return $sformatf({"ev=%0d tx=%02h last=%0d pwr=%0d mode=%0d fan=%0d tgt=%0d",
                           " swing=%0d room=%0d"},
                          r.ev, r.tx_byte, r.last_byte, r.power, r.mode, r.fan, r.target,
                          r.swing, r.room_half);
      endfunction

      function void check_result(codec_result_type seen);
         codec_result_type want;
         if (pending_results.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT) $display("ERROR: result with none expected: %s",
                                                   describe(seen));
            return;
         end
         want = pending_results.pop_front();
         compared++;
         if (seen !== want) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("ERROR: result %0d mismatch", compared);
               $display("   expected %s", describe(want));
               $display("   actual   %s", describe(seen));
            end
         end
      endfunction

      function int unsigned close_out();
         if (pending_results.size() != 0) begin
            $display("ERROR: %0d expected results never arrived", pending_results.size());
            failures += pending_results.size();
         end
         return failures;
      endfunction
   endclass

endpackage

@@ sim/tb_top.sv @@
// Top-level testbench of aircon_status_frame_codec_unit: clock, reset, request and
// response drivers with random idling, and the end-of-run report.
// Depends on acsfc_pkg and on the scoreboard in acsfc_tb_pkg.

module tb_top;

   import acsfc_pkg::*;
   import acsfc_tb_pkg::*;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_command;
   logic [7:0] req_rx_byte;
   logic       req_power_on;
   logic [2:0] req_mode_request;
   logic [2:0] req_fan_request;
   logic       req_swing_request;
   logic [4:0] req_target_temp;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [1:0] rsp_event_res;
   logic [7:0] rsp_tx_byte;
   logic       rsp_last_byte;
   logic       rsp_power_state;
   logic [2:0] rsp_mode_state;
   logic [2:0] rsp_fan_state;
   logic [4:0] rsp_target_state;
   logic       rsp_swing_state;
   logic [6:0] rsp_room_temp_half;

   status_codec_scoreboard sb;
   codec_result_type       seen_result;
   int unsigned            items_sent;
   int unsigned            sender_idle_pct;

   aircon_status_frame_codec_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_rx_byte        (req_rx_byte),
      .req_power_on       (req_power_on),
      .req_mode_request   (req_mode_request),
      .req_fan_request    (req_fan_request),
      .req_swing_request  (req_swing_request),
      .req_target_temp    (req_target_temp),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_res      (rsp_event_res),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_last_byte      (rsp_last_byte),
      .rsp_power_state    (rsp_power_state),
      .rsp_mode_state     (rsp_mode_state),
      .rsp_fan_state      (rsp_fan_state),
      .rsp_target_state   (rsp_target_state),
      .rsp_swing_state    (rsp_swing_state),
      .rsp_room_temp_half (rsp_room_temp_half)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #9_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int unsigned stall_left;
      int unsigned calm_left;
      int unsigned r;
      stall_left = 0;
      calm_left = 0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (calm_left != 0) begin
               calm_left--;
            end else begin
               r = $urandom_range(0, 99);
               if (r < 4) calm_left = $urandom_range(40, 200);
               else if (r < 22) stall_left = $urandom_range(1, 3);
               else if (r < 25) stall_left = $urandom_range(8, 40);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_result.ev = event_type'(rsp_event_res);
         seen_result.tx_byte = rsp_tx_byte;
         seen_result.last_byte = rsp_last_byte;
         seen_result.power = rsp_power_state;
         seen_result.mode = rsp_mode_state;
         seen_result.fan = rsp_fan_state;
         seen_result.target = rsp_target_state;
         seen_result.swing = rsp_swing_state;
         seen_result.room_half = rsp_room_temp_half;
         sb.check_result(seen_result);
      end
   end

   function automatic int unsigned sender_gap();
      if (sender_idle_pct == 0 || $urandom_range(0, 99) >= sender_idle_pct) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Called right after a falling edge; returns right after the falling edge that
   // follows acceptance of the transaction.
   task automatic send_item(command_type cmd, bit [7:0] rx, bit pwr, bit [2:0] mode_req,
                            bit [2:0] fan_req, bit swing_req, bit [4:0] target);
      int unsigned idle;
      idle = sender_gap();
      repeat (idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_rx_byte <= rx;
      req_power_on <= pwr;
      req_mode_request <= mode_req;
      req_fan_request <= fan_req;
      req_swing_request <= swing_req;
      req_target_temp <= target;
      do @(posedge clock); while (!req_ready);
      sb.note_request(cmd, rx, pwr, mode_req, fan_req, swing_req, target);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_plain(command_type cmd, bit [7:0] rx);
      send_item(cmd, rx, 1'($urandom), 3'($urandom), 3'($urandom), 1'($urandom),
                5'($urandom));
   endtask

   task automatic send_tx_random();
      if ($urandom_range(0, 3) == 0) begin
         send_plain(CMD_PROBE, 8'($urandom));
      end else begin
         send_item(CMD_SETTINGS, 8'($urandom), 1'($urandom),
                   ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 5))
                                              : 3'($urandom_range(6, 7)),
                   ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4))
                                              : 3'($urandom_range(5, 7)),
                   1'($urandom),
                   ($urandom_range(0, 9) < 8) ? 5'($urandom_range(15, 30))
                                              : 5'($urandom_range(0, 31)));
      end
   endtask

   task automatic send_frame(frame_kind_type kind);
      bit [7:0]    frame [FRAME_LEN];
      bit [7:0]    sum;
      int unsigned cut;
      if (sb.rx_count != 0) send_plain(CMD_GAP, 8'($urandom));
      for (int k = 0; k < PAYLOAD_LEN; k++) frame[k] = 8'($urandom);
      case (kind)
         FRAME_STATUS: frame[0] = UNIT_FRAME_TYPE;
         FRAME_OTHER: begin
            case ($urandom_range(0, 2))
               0:       frame[0] = UNIT_FRAME_TYPE | 8'($urandom_range(1, 7));
               1:       frame[0] = HOST_FRAME_TYPE;
               default: frame[0] = 8'($urandom);
            endcase
         end
         default: ;
      endcase
      sum = 8'h00;
      for (int k = 0; k < PAYLOAD_LEN; k++) sum += frame[k];
      frame[PAYLOAD_LEN] = sum ^ FRAME_CHECK_MASK;
      if (kind == FRAME_BAD_CHECK) frame[PAYLOAD_LEN] ^= 8'($urandom_range(1, 255));
      cut = (kind == FRAME_CUT) ? $urandom_range(1, PAYLOAD_LEN) : FRAME_LEN;
      for (int k = 0; k < cut; k++) begin
         if ($urandom_range(0, 99) < 4) send_tx_random();
         send_plain(CMD_RX_BYTE, frame[k]);
      end
      if (kind == FRAME_CUT) send_plain(CMD_GAP, 8'($urandom));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.results_outstanding() != 0);
   endtask

   initial begin
      bit [7:0]    status_bytes [FRAME_LEN];
      bit [7:0]    sum;
      int unsigned next_phase;
      int unsigned r;
      int unsigned failures;
      req_valid = 1'b0;
      req_command = CMD_GAP;
      req_rx_byte = 8'h00;
      req_power_on = 1'b0;
      req_mode_request = 3'd0;
      req_fan_request = 3'd0;
      req_swing_request = 1'b0;
      req_target_temp = 5'd15;
      reset = 1'b1;
      sb = new();
      items_sent = 0;
      sender_idle_pct = 30;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_item(CMD_SETTINGS, 8'h00, 1'b1, 3'd5, 3'd4, 1'b1, 5'd30);
      send_item(CMD_PROBE, 8'hFF, 1'b0, 3'd0, 3'd0, 1'b0, 5'd0);
      status_bytes = '{8'hC8, 8'hFF, 8'hC0, 8'h12, 8'h34, 8'h01, 8'h0F, 8'h3F,
                       8'hFF, 8'h00, 8'hAA, 8'h55, 8'h00};
      sum = 8'h00;
      for (int k = 0; k < PAYLOAD_LEN; k++) sum += status_bytes[k];
      status_bytes[PAYLOAD_LEN] = sum ^ FRAME_CHECK_MASK;
      for (int k = 0; k < FRAME_LEN; k++) send_plain(CMD_RX_BYTE, status_bytes[k]);
      send_item(CMD_SETTINGS, 8'h00, 1'b0, 3'd7, 3'd7, 1'b0, 5'd0);
      send_item(CMD_SETTINGS, 8'hFF, 1'b1, 3'd0, 3'd0, 1'b1, 5'd31);
      send_plain(CMD_RX_BYTE, UNIT_FRAME_TYPE);
      send_plain(CMD_RX_BYTE, 8'h00);
      send_plain(CMD_RX_BYTE, 8'h00);
      send_plain(CMD_GAP, 8'h00);
      drain_results();

      next_phase = items_sent + 60;
      while (items_sent < 380) begin
         if (items_sent >= next_phase) begin
            // The sender holds off until the block has delivered everything.
            drain_results();
            case ($urandom_range(0, 2))
               0:       sender_idle_pct = 0;
               1:       sender_idle_pct = 20;
               default: sender_idle_pct = 60;
            endcase
            next_phase = items_sent + 60;
         end
         r = $urandom_range(0, 99);
         if (r < 30) send_frame(FRAME_STATUS);
         else if (r < 45) send_frame(FRAME_OTHER);
         else if (r < 55) send_frame(FRAME_BAD_CHECK);
         else if (r < 63) send_frame(FRAME_CUT);
         else if (r < 85) send_tx_random();
         else if (r < 94) send_plain(CMD_RX_BYTE, 8'($urandom));
         else send_plain(CMD_GAP, 8'($urandom));
      end

      drain_results();
      repeat (20) @(posedge clock);
      failures = sb.close_out();
      $display("Summary: %0d requests, %0d frames transmitted, %0d status frames stored.",
               items_sent, sb.frames_sent, sb.status_frames);
      $display("Summary: %0d other frames, %0d check errors, %0d results compared, %0d failures.",
               sb.other_frames, sb.check_errors, sb.compared, failures);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/acsfc_pkg.sv
hw/rtl/acsfc_ctrl.sv
hw/rtl/acsfc_datapath.sv
hw/rtl/aircon_status_frame_codec_unit.sv
sim/acsfc_tb_pkg.sv
sim/tb_top.sv
